>>> rtl/arm_axis_speed_hold_pid_with_limits_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arm axis speed-hold unit
// Concurrent assertion shorthands clocked on clock; all but the _NR one are gated by reset.
// ----------------------------------------------------------------------------
`ifndef ARM_AXIS_SPEED_HOLD_PID_WITH_LIMITS_UNIT_MACROS_SVH
`define ARM_AXIS_SPEED_HOLD_PID_WITH_LIMITS_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define AHSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define AHSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always on
`define AHSP_ASSERT_NEXT_NR(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ahsp_pkg.sv
// ----------------------------------------------------------------------------
// ahsp_pkg
// Shared types, constants and helpers of the arm axis speed-hold unit.
// ----------------------------------------------------------------------------
package ahsp_pkg;

   localparam int MAX_AXES      = 7;
   localparam int DEF_AXES      = 7;
   localparam int DEF_BASE_AXIS = 0;
   localparam int GAIN_W        = 9;
   localparam int GAINS_W       = 63;
   localparam int REG_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [GAINS_W-1:0] KP_RESET  = 63'd2306442964679327872;
   localparam logic [GAINS_W-1:0] KI_RESET  = 63'd0;
   localparam logic [GAINS_W-1:0] KD_RESET  = 63'd140737488355328;
   localparam logic [14:0]        CMAX_RESET = 15'd16384;
   localparam logic signed [15:0] CMIN_RESET = -16'sd16384;
   localparam logic [14:0]        ESC_RESET  = 15'd2000;

   localparam logic [REG_INDEX_W-1:0] REG_KP   = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_KI   = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_KD   = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_CMAX = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_CMIN = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_ESC  = 3'd5;

   typedef enum logic [2:0] {
      KIND_PID     = 3'd0,
      KIND_PASS    = 3'd1,
      KIND_ZERO    = 3'd2,
      KIND_ESC_NEG = 3'd3,
      KIND_ESC_POS = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]         axis;
      logic signed [15:0] manual;
      logic signed [15:0] rpm;
      logic               in_range;
      kind_type           kind;
      logic [2:0]         flags;
   } item_type;

   typedef struct packed {
      logic [GAINS_W-1:0] kp;
      logic [GAINS_W-1:0] ki;
      logic [GAINS_W-1:0] kd;
      logic [14:0]        cmd_max;
      logic signed [15:0] cmd_min;
      logic [14:0]        esc;
   } cfg_type;

   function automatic logic [GAIN_W-1:0] gain_of(input logic [GAINS_W-1:0] packed_gains,
                                                  input logic [2:0] axis);
      logic [GAIN_W-1:0] g;
      g = '0;
      for (int i = 0; i < MAX_AXES; i++) begin
         if (axis == 3'(i)) begin
            g = packed_gains[GAIN_W*i +: GAIN_W];
         end
      end
      return g;
   endfunction

endpackage

>>> rtl/ahsp_csr.sv
// ----------------------------------------------------------------------------
// ahsp_csr
// Configuration registers: gains, command clamps and escape magnitude.
// ----------------------------------------------------------------------------
module ahsp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ahsp_pkg::REG_INDEX_W-1:0]    csr_index,
   input  logic [ahsp_pkg::CSR_DATA_W-1:0]     csr_data,
   output ahsp_pkg::cfg_type                   cfg
);

   ahsp_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp      <= ahsp_pkg::KP_RESET;
         cfg_ff.ki      <= ahsp_pkg::KI_RESET;
         cfg_ff.kd      <= ahsp_pkg::KD_RESET;
         cfg_ff.cmd_max <= ahsp_pkg::CMAX_RESET;
         cfg_ff.cmd_min <= ahsp_pkg::CMIN_RESET;
         cfg_ff.esc     <= ahsp_pkg::ESC_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ahsp_pkg::REG_KP:   cfg_ff.kp      <= csr_data[ahsp_pkg::GAINS_W-1:0];
            ahsp_pkg::REG_KI:   cfg_ff.ki      <= csr_data[ahsp_pkg::GAINS_W-1:0];
            ahsp_pkg::REG_KD:   cfg_ff.kd      <= csr_data[ahsp_pkg::GAINS_W-1:0];
            ahsp_pkg::REG_CMAX: cfg_ff.cmd_max <= csr_data[14:0];
            ahsp_pkg::REG_CMIN: cfg_ff.cmd_min <= csr_data[15:0];
            ahsp_pkg::REG_ESC:  cfg_ff.esc     <= csr_data[14:0];
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/ahsp_front.sv
// ----------------------------------------------------------------------------
// ahsp_front
// Input side: unpacks a sample and classifies it for the back end.
// ----------------------------------------------------------------------------
module ahsp_front #(
   parameter int AXES      = ahsp_pkg::DEF_AXES,
   parameter int BASE_AXIS = ahsp_pkg::DEF_BASE_AXIS
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,
   input  logic [4:0]         req_tuser,
   output logic               push_valid,
   input  logic               push_ready,
   output ahsp_pkg::item_type push_item
);

   logic [2:0]         axis;
   logic signed [15:0] manual;
   logic               right;
   logic               left;
   logic               in_range;
   logic               is_base;
   logic               man_pos;
   logic               man_neg;

   assign axis   = req_tdata[2:0];
   assign manual = req_tdata[18:3];
   assign right  = req_tuser[0];
   assign left   = req_tuser[1];

   assign in_range = ({1'b0, axis} < 4'(AXES));
   assign is_base  = in_range && (axis == 3'(BASE_AXIS));
   assign man_neg  = manual[15];
   assign man_pos  = !manual[15] && (manual != 16'sd0);

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_item.axis     = axis;
      push_item.manual   = manual;
      push_item.rpm      = req_tdata[34:19];
      push_item.in_range = in_range;
      push_item.flags    = req_tuser[4:2];
      if (!in_range) begin
         push_item.kind = ahsp_pkg::KIND_PASS;
      end else if (is_base && right && left) begin
         push_item.kind = ahsp_pkg::KIND_ZERO;
      end else if (is_base && right && man_pos) begin
         push_item.kind = ahsp_pkg::KIND_ESC_NEG;
      end else if (is_base && left && man_neg) begin
         push_item.kind = ahsp_pkg::KIND_ESC_POS;
      end else if (manual != 16'sd0) begin
         push_item.kind = ahsp_pkg::KIND_PASS;
      end else begin
         push_item.kind = ahsp_pkg::KIND_PID;
      end
   end

endmodule

>>> rtl/ahsp_queue.sv
// ----------------------------------------------------------------------------
// ahsp_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module ahsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ahsp_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ahsp_pkg::item_type pop_item
);

   ahsp_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_in;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/ahsp_back.sv
// ----------------------------------------------------------------------------
// ahsp_back
// Back end: per-axis PID state, multiply, sum, scale and clamp, output.
// ----------------------------------------------------------------------------
module ahsp_back #(
   parameter int AXES = ahsp_pkg::DEF_AXES
) (
   input  logic               clock,
   input  logic               reset,
   input  ahsp_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  ahsp_pkg::item_type pop_item,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic [2:0]         rsp_tuser
);

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

   logic signed [31:0] integ_ff [AXES];
   logic signed [16:0] prev_ff  [AXES];

   logic advance;
   logic fire_a;
   logic [AXIS_W-1:0] idx;

   logic signed [16:0] err_in;
   logic signed [32:0] isum;
   logic signed [31:0] integ_in;
   logic signed [17:0] derr_in;

   logic                         a_valid_ff;
   ahsp_pkg::item_type           a_item_ff;
   logic signed [16:0]           a_err_ff;
   logic signed [31:0]           a_integ_ff;
   logic signed [17:0]           a_derr_ff;
   logic [ahsp_pkg::GAIN_W-1:0]  a_kp_ff;
   logic [ahsp_pkg::GAIN_W-1:0]  a_ki_ff;
   logic [ahsp_pkg::GAIN_W-1:0]  a_kd_ff;

   logic               b_valid_ff;
   ahsp_pkg::item_type b_item_ff;
   logic signed [26:0] b_p_ff;
   logic signed [41:0] b_i_ff;
   logic signed [27:0] b_d_ff;

   logic               c_valid_ff;
   ahsp_pkg::item_type c_item_ff;
   logic signed [42:0] c_sum_ff;

   logic signed [42:0] biased;
   logic signed [42:0] quot;
   logic signed [42:0] max_s;
   logic signed [42:0] min_s;
   logic signed [15:0] pid_cmd;
   logic signed [15:0] cmd_in;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_axis_ff;
   logic signed [15:0] rsp_cmd_ff;
   logic [2:0]         rsp_flags_ff;

   assign advance   = !rsp_valid_ff || rsp_tready;
   assign pop_ready = advance;
   assign fire_a    = pop_valid && advance;
   assign idx       = pop_item.axis[AXIS_W-1:0];

   // stage A: error terms and saturated integral
   always_comb begin
      err_in  = 17'sd0 - 17'(pop_item.rpm);
      isum    = 33'(integ_ff[idx]) + 33'(err_in);
      if (isum[32] != isum[31]) begin
         integ_in = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         integ_in = isum[31:0];
      end
      derr_in = 18'(err_in) - 18'(prev_ff[idx]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else if (fire_a && pop_item.in_range) begin
         if (pop_item.kind == ahsp_pkg::KIND_PID) begin
            integ_ff[idx] <= integ_in;
            prev_ff[idx]  <= err_in;
         end else begin
            integ_ff[idx] <= '0;
            prev_ff[idx]  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= pop_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   // stage D: divide by 128 toward zero, clamp, select
   always_comb begin
      biased  = c_sum_ff + (c_sum_ff[42] ? 43'sd127 : 43'sd0);
      quot    = biased >>> 7;
      max_s   = 43'($signed({1'b0, cfg.cmd_max}));
      min_s   = 43'(cfg.cmd_min);
      if (quot > max_s) begin
         pid_cmd = $signed({1'b0, cfg.cmd_max});
      end else if (quot < min_s) begin
         pid_cmd = cfg.cmd_min;
      end else begin
         pid_cmd = quot[15:0];
      end
      case (c_item_ff.kind)
         ahsp_pkg::KIND_PID:     cmd_in = pid_cmd;
         ahsp_pkg::KIND_PASS:    cmd_in = c_item_ff.manual;
         ahsp_pkg::KIND_ZERO:    cmd_in = 16'sd0;
         ahsp_pkg::KIND_ESC_NEG: cmd_in = 16'sd0 - $signed({1'b0, cfg.esc});
         ahsp_pkg::KIND_ESC_POS: cmd_in = $signed({1'b0, cfg.esc});
         default:                cmd_in = 16'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff  <= pop_item;
         a_err_ff   <= err_in;
         a_integ_ff <= integ_in;
         a_derr_ff  <= derr_in;
         a_kp_ff    <= ahsp_pkg::gain_of(cfg.kp, pop_item.axis);
         a_ki_ff    <= ahsp_pkg::gain_of(cfg.ki, pop_item.axis);
         a_kd_ff    <= ahsp_pkg::gain_of(cfg.kd, pop_item.axis);

         b_item_ff  <= a_item_ff;
         b_p_ff     <= $signed({1'b0, a_kp_ff}) * a_err_ff;
         b_i_ff     <= $signed({1'b0, a_ki_ff}) * a_integ_ff;
         b_d_ff     <= $signed({1'b0, a_kd_ff}) * a_derr_ff;

         c_item_ff  <= b_item_ff;
         c_sum_ff   <= 43'(b_p_ff) + 43'(b_i_ff) + 43'(b_d_ff);

         rsp_axis_ff  <= c_item_ff.axis;
         rsp_cmd_ff   <= cmd_in;
         rsp_flags_ff <= c_item_ff.flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_cmd_ff, rsp_axis_ff};
   assign rsp_tuser  = rsp_flags_ff;

endmodule

>>> rtl/arm_axis_speed_hold_pid_with_limits_unit.sv
// ----------------------------------------------------------------------------
// arm_axis_speed_hold_pid_with_limits_unit
// Per-axis speed-hold PID with limit-switch escape for a multi-axis arm.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one axis sample per transfer; rsp_* returns exactly one
//   motor command per sample, in order. csr_* writes a register by index
//   (0 kp, 1 ki, 2 kd, 3 command max, 4 command min, 5 escape); csr_ready
//   is always high. Write registers only while the block is idle.
//   Throughput: one sample per cycle while the output is not stalled; the
//   back end is a four-stage pipeline (state update, gain multiplies,
//   sum, scale and clamp) and per-axis state is updated in its first
//   stage, so samples of the same axis can follow each other directly.
//   Reset clears all per-axis PID state, restores register defaults and
//   empties the pipeline and the two-entry input queue.
//   When a result is held with rsp_tready low the whole back end holds;
//   the queue then fills and req_tready drops after two more samples.
// ----------------------------------------------------------------------------
module arm_axis_speed_hold_pid_with_limits_unit #(
   parameter int AXES      = ahsp_pkg::DEF_AXES,
   parameter int BASE_AXIS = ahsp_pkg::DEF_BASE_AXIS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] axis_index, [18:3] manual_value, [34:19] measured_rpm, zero pad
   input  logic [39:0]                      req_tdata,
   // [0] right_stop, [1] left_stop, [2] keyboard_enable,
   // [3] extend_push, [4] extend_pull
   input  logic [4:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] axis_out, [18:3] motor_command, zero pad
   output logic [23:0]                      rsp_tdata,
   // [0] keyboard_enable_out, [1] extend_push_out, [2] extend_pull_out
   output logic [2:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ahsp_pkg::REG_INDEX_W-1:0] csr_index,
   input  logic [ahsp_pkg::CSR_DATA_W-1:0]  csr_data
);

   ahsp_pkg::cfg_type  cfg;
   ahsp_pkg::item_type push_item;
   ahsp_pkg::item_type pop_item;
   logic push_valid;
   logic push_ready;
   logic pop_valid;
   logic pop_ready;

   ahsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ahsp_front #(
      .AXES      (AXES),
      .BASE_AXIS (BASE_AXIS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ahsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ahsp_back #(
      .AXES (AXES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/ahsp_checker.sv
// ----------------------------------------------------------------------------
// ahsp_checker
// Port-level checks of the speed-hold unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm_axis_speed_hold_pid_with_limits_unit_macros.svh"

module ahsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   `AHSP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `AHSP_ASSERT_NEXT_NR(a_reset_empty, reset, !rsp_tvalid, "result valid right after reset")
   `AHSP_ASSERT_IMP(a_min_latency, $rose(rsp_tvalid), !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3), "result too soon after reset")
   // input queue can only be full while a result is held at the output
   `AHSP_ASSERT_IMP(a_backpressure, !req_tready, rsp_tvalid, "input stalled with no result pending")

   logic unused_valid;
   assign unused_valid = req_tvalid;

endmodule

bind arm_axis_speed_hold_pid_with_limits_unit ahsp_checker u_ahsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> test/arm_axis_speed_hold_pid_with_limits_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_axis_speed_hold_pid_with_limits_unit_test
// Self-checking bench for the arm axis speed-hold unit. Samples go in over the
// req stream and commands come back over the rsp stream. Both sides stall at
// random. Each accepted sample runs through a local speed-hold predictor, and
// each returned command is checked field by field against the oldest one
// predicted. A short table of directed samples runs at the reset register
// values. Random phases follow over several register settings, including
// all-ones and all-zero gains, crossed clamp limits and same-axis runs at a
// fixed speed.
// ----------------------------------------------------------------------------
module arm_axis_speed_hold_pid_with_limits_unit_test;

   localparam int AXIS_COUNT   = ahsp_pkg::DEF_AXES;
   localparam int BASE         = ahsp_pkg::DEF_BASE_AXIS;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam logic [ahsp_pkg::REG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [ahsp_pkg::REG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0]         axis;
      logic signed [15:0] command;
      logic [2:0]         flags;    // {extend_pull, extend_push, keyboard_enable}
   } motor_cmd_type;

   typedef struct packed {
      logic               known;
      logic signed [15:0] command;
   } directed_cmd_type;

   typedef struct packed {
      logic [2:0]         axis;
      logic signed [15:0] manual;
      logic signed [15:0] rpm;
      logic               right;
      logic               left;
      logic [2:0]         flags;
      logic               known;
      logic signed [15:0] command;
   } sample_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [ahsp_pkg::REG_INDEX_W-1:0] csr_index = '0;
   logic [ahsp_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of registers and per-axis state
   logic [ahsp_pkg::GAINS_W-1:0] kp_set = ahsp_pkg::KP_RESET;
   logic [ahsp_pkg::GAINS_W-1:0] ki_set = ahsp_pkg::KI_RESET;
   logic [ahsp_pkg::GAINS_W-1:0] kd_set = ahsp_pkg::KD_RESET;
   int cmd_ceiling  = int'(ahsp_pkg::CMAX_RESET);
   int cmd_floor    = int'(ahsp_pkg::CMIN_RESET);
   int escape_level = int'(ahsp_pkg::ESC_RESET);
   int error_sum  [AXIS_COUNT] = '{default: 0};
   int last_error [AXIS_COUNT] = '{default: 0};

   motor_cmd_type    pending_commands [$];
   directed_cmd_type directed_cmds [$];

   int   samples_taken = 0;
   int   commands_seen = 0;
   int   csr_writes = 0;
   int   failures = 0;
   logic steady = 1'b0;

   localparam int DIRECTED_ROWS = 22;
   sample_row_type directed_rows [DIRECTED_ROWS] = '{
      '{3'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 3'b000, 1'b1, 16'sd0},
      '{3'd1, 16'sd32767,  16'sh8000,   1'b0, 1'b0, 3'b111, 1'b1, 16'sd32767},
      '{3'd2, 16'sh8000,   16'sd32767,  1'b1, 1'b1, 3'b000, 1'b1, 16'sh8000},
      '{3'd0, 16'sd0,      16'sd1000,   1'b0, 1'b0, 3'b001, 1'b0, 16'sd0},
      '{3'd0, 16'sd0,      16'sh8000,   1'b0, 1'b0, 3'b010, 1'b0, 16'sd0},
      '{3'd0, 16'sd0,      16'sd32767,  1'b0, 1'b0, 3'b100, 1'b0, 16'sd0},
      '{3'd3, 16'sd0,      16'sd32767,  1'b0, 1'b0, 3'b011, 1'b0, 16'sd0},
      '{3'd6, 16'sd0,      16'sh8000,   1'b0, 1'b0, 3'b101, 1'b0, 16'sd0},
      '{3'd6, 16'sd0,      16'sh8000,   1'b0, 1'b0, 3'b110, 1'b0, 16'sd0},
      '{3'd7, 16'sd0,      16'sd5000,   1'b1, 1'b1, 3'b111, 1'b1, 16'sd0},
      '{3'd7, -16'sd1234,  16'sh8000,   1'b1, 1'b0, 3'b001, 1'b1, -16'sd1234},
      '{3'd0, 16'sd0,      16'sd300,    1'b1, 1'b1, 3'b000, 1'b1, 16'sd0},
      '{3'd0, 16'sd500,    16'sd0,      1'b1, 1'b0, 3'b010, 1'b1, -16'sd2000},
      '{3'd0, -16'sd500,   16'sd0,      1'b0, 1'b1, 3'b100, 1'b1, 16'sd2000},
      '{3'd0, -16'sd500,   16'sd0,      1'b1, 1'b0, 3'b000, 1'b1, -16'sd500},
      '{3'd0, 16'sd500,    16'sd0,      1'b0, 1'b1, 3'b111, 1'b1, 16'sd500},
      '{3'd0, 16'sd0,      16'sd700,    1'b1, 1'b0, 3'b000, 1'b0, 16'sd0},
      '{3'd0, 16'sd0,      -16'sd700,   1'b0, 1'b1, 3'b001, 1'b0, 16'sd0},
      '{3'd4, 16'sd100,    16'sd0,      1'b1, 1'b1, 3'b010, 1'b1, 16'sd100},
      '{3'd5, 16'sd0,      -16'sd20000, 1'b0, 1'b0, 3'b000, 1'b0, 16'sd0},
      '{3'd5, 16'sd0,      -16'sd20000, 1'b0, 1'b0, 3'b000, 1'b0, 16'sd0},
      '{3'd6, -16'sd7,     16'sd0,      1'b0, 1'b0, 3'b101, 1'b1, -16'sd7}
   };

   arm_axis_speed_hold_pid_with_limits_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint axis_gain(input logic [ahsp_pkg::GAINS_W-1:0] gains,
                                        input logic [2:0] axis);
      return longint'(gains[ahsp_pkg::GAIN_W*axis +: ahsp_pkg::GAIN_W]);
   endfunction

   function automatic void clear_axis_state(input logic [2:0] axis);
      error_sum[axis]  = 0;
      last_error[axis] = 0;
   endfunction

   function automatic motor_cmd_type hold_speed_command(input logic [39:0] data,
                                                        input logic [4:0] user);
      logic [2:0]         axis;
      logic signed [15:0] manual;
      logic signed [15:0] rpm;
      longint             err;
      longint             integ;
      longint             total;
      longint             scaled;
      int                 command;
      motor_cmd_type      r;
      axis   = data[2:0];
      manual = data[18:3];
      rpm    = data[34:19];
      if (axis >= AXIS_COUNT) begin
         command = manual;
      end else begin
         if (manual != 0) begin
            command = manual;
            clear_axis_state(axis);
         end else begin
            err   = -longint'(rpm);
            integ = longint'(error_sum[axis]) + err;
            if (integ > 64'sd2147483647) integ = 64'sd2147483647;
            if (integ < -64'sd2147483648) integ = -64'sd2147483648;
            error_sum[axis] = int'(integ);
            total = axis_gain(kp_set, axis) * err
                  + axis_gain(ki_set, axis) * integ
                  + axis_gain(kd_set, axis) * (err - longint'(last_error[axis]));
            last_error[axis] = int'(err);
            scaled = total / 128;
            if (scaled > longint'(cmd_ceiling)) command = cmd_ceiling;
            else if (scaled < longint'(cmd_floor)) command = cmd_floor;
            else command = int'(scaled);
         end
         if (axis == BASE) begin
            if (user[0] && user[1]) begin
               command = 0;
               clear_axis_state(axis);
            end else if (user[0] && manual > 0) begin
               command = -escape_level;
               clear_axis_state(axis);
            end else if (user[1] && manual < 0) begin
               command = escape_level;
               clear_axis_state(axis);
            end
         end
      end
      r.axis    = axis;
      r.command = command[15:0];
      r.flags   = user[4:2];
      return r;
   endfunction

   function automatic void apply_register(input logic [ahsp_pkg::REG_INDEX_W-1:0] index,
                                          input logic [ahsp_pkg::CSR_DATA_W-1:0] data);
      case (index)
         ahsp_pkg::REG_KP:   kp_set = data[ahsp_pkg::GAINS_W-1:0];
         ahsp_pkg::REG_KI:   ki_set = data[ahsp_pkg::GAINS_W-1:0];
         ahsp_pkg::REG_KD:   kd_set = data[ahsp_pkg::GAINS_W-1:0];
         ahsp_pkg::REG_CMAX: cmd_ceiling = int'(data[14:0]);
         ahsp_pkg::REG_CMIN: cmd_floor = int'($signed(data[15:0]));
         ahsp_pkg::REG_ESC:  escape_level = int'(data[14:0]);
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      motor_cmd_type    got;
      motor_cmd_type    want;
      directed_cmd_type hint;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            want = hold_speed_command(req_tdata, req_tuser);
            if (directed_cmds.size() != 0) begin
               hint = directed_cmds.pop_front();
               if (hint.known) want.command = hint.command;
            end
            pending_commands.push_back(want);
            samples_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[2:0], rsp_tdata[18:3], rsp_tuser};
            if (pending_commands.size() == 0) begin
               $error("motor command with no sample waiting: axis %0d command %0d",
                      got.axis, $signed(got.command));
               failures++;
            end else begin
               want = pending_commands.pop_front();
               check_field("axis_out", want.axis, got.axis);
               check_field("motor_command", $signed(want.command), $signed(got.command));
               check_field("keyboard_enable_out", want.flags[0], got.flags[0]);
               check_field("extend_push_out", want.flags[1], got.flags[1]);
               check_field("extend_pull_out", want.flags[2], got.flags[2]);
            end
            commands_seen++;
         end
      end
   end

   // receiver: random stall before each command transfer
   initial begin
      int stall;
      int seen;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         seen = commands_seen;
         do @(negedge clock); while (commands_seen == seen);
      end
   end

   task automatic send_sample(input logic [2:0] axis, input logic signed [15:0] manual,
                              input logic signed [15:0] rpm, input logic right,
                              input logic left, input logic [2:0] flags,
                              input logic known, input logic signed [15:0] command);
      int gap;
      int taken;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      directed_cmds.push_back('{known, command});
      req_tdata  = {5'b0, rpm, manual, axis};
      req_tuser  = {flags, left, right};
      req_tvalid = 1'b1;
      taken = samples_taken;
      do @(negedge clock); while (samples_taken == taken);
   endtask

   function automatic logic signed [15:0] pick_speed();
      logic signed [15:0] v;
      case ($urandom_range(0, 3))
         0: v = 16'($urandom);
         1: v = 16'(int'($urandom_range(0, 510)) - 255);
         2: case ($urandom_range(0, 3))
               0: v = 16'sh8000;
               1: v = 16'sd32767;
               2: v = -16'sd1;
               default: v = 16'sd1;
            endcase
         default: v = 16'(int'($urandom_range(0, 8190)) - 4095);
      endcase
      return v;
   endfunction

   task automatic send_random_samples(input int count);
      logic [2:0]         axis = 3'd0;
      logic signed [15:0] manual;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) axis = 3'(BASE);
            else if (pick == 3) axis = 3'd7;
            else axis = 3'($urandom_range(1, AXIS_COUNT - 1));
         end
         manual = ($urandom_range(0, 9) < 6) ? 16'sd0 : pick_speed();
         send_sample(axis, manual, pick_speed(), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 1'b0, 16'sd0);
      end
   endtask

   // runs on one axis with one speed, so the integral builds up
   task automatic hold_axis_speed(input logic [2:0] axis, input logic signed [15:0] rpm,
                                  input int count);
      for (int n = 0; n < count; n++)
         send_sample(axis, 16'sd0, rpm, 1'b0, 1'b0, 3'($urandom_range(0, 7)), 1'b0, 16'sd0);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_register(input logic [ahsp_pkg::REG_INDEX_W-1:0] index,
                                 input logic [ahsp_pkg::CSR_DATA_W-1:0] data);
      int writes_done;
      writes_done = csr_writes;
      csr_index   = index;
      csr_data    = data;
      csr_valid   = 1'b1;
      do @(negedge clock); while (csr_writes == writes_done);
   endtask

   task automatic load_settings(input logic [63:0] kp, input logic [63:0] ki,
                                input logic [63:0] kd, input logic [63:0] cmax,
                                input logic [63:0] cmin, input logic [63:0] esc);
      wait_idle();
      write_register(ahsp_pkg::REG_KP, kp);
      write_register(ahsp_pkg::REG_KI, ki);
      write_register(ahsp_pkg::REG_KD, kd);
      write_register(ahsp_pkg::REG_CMAX, cmax);
      write_register(ahsp_pkg::REG_CMIN, cmin);
      write_register(ahsp_pkg::REG_ESC, esc);
      write_register(REG_SPARE_A, {$urandom, $urandom});
      write_register(REG_SPARE_B, {$urandom, $urandom});
      csr_valid = 1'b0;
   endtask

   initial begin
      int cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("arm_axis_speed_hold_pid_with_limits_unit: mismatch");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].axis, directed_rows[i].manual, directed_rows[i].rpm,
                     directed_rows[i].right, directed_rows[i].left, directed_rows[i].flags,
                     directed_rows[i].known, directed_rows[i].command);

      // random gains and limits, with a full drain midway
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, 16'h8000 | 16'($urandom)},
                    {$urandom, $urandom});
      send_random_samples(60);
      wait_idle();
      send_random_samples(60);

      // gains, command max and escape at their top, command min at its bottom, then same-axis runs
      load_settings('1, '1, '1, '1, {48'hFFFF_FFFF_FFFF, 16'h8000}, '1);
      send_random_samples(90);
      steady = 1'b1;
      hold_axis_speed(3'd2, 16'sh8000, 30);
      hold_axis_speed(3'd2, 16'sd32767, 4);
      hold_axis_speed(3'd3, 16'sd32767, 30);
      hold_axis_speed(3'd3, -16'sd5, 4);
      steady = 1'b0;

      load_settings('0, '0, '0, '0, '0, '0);
      send_random_samples(50);

      // command_min above command_max
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    64'($urandom_range(0, 200)), 64'($urandom_range(300, 32767)),
                    {$urandom, $urandom});
      send_random_samples(100);

      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_random_samples(80);

      wait_idle();
      if (failures == 0) begin
         $display("arm_axis_speed_hold_pid_with_limits_unit: match");
      end else begin
         $display("arm_axis_speed_hold_pid_with_limits_unit: mismatch");
      end
      $finish;
   end

endmodule
